FILE: src/aec_pkg.sv
`timescale 1ns / 1ps

package aec_pkg;

  // default sizing
  localparam int unsigned MAX_THRESHOLD = 16;
  localparam int unsigned TIME_WIDTH    = 32;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned TagW     = 16;
  localparam int unsigned ReasonW  = 2;
  localparam int unsigned ThrW     = 5;
  localparam int unsigned WindowW  = 12;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // window limit in ms: window_seconds * 1000 + 999 fits in 22 bits
  localparam int unsigned LimW     = 22;
  localparam int unsigned MsPerSec = 1000;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK     = 2'd0;
  localparam logic [OpW-1:0] OP_ALERT    = 2'd1;
  localparam logic [OpW-1:0] OP_RESPONSE = 2'd2;

  // escalation reasons
  localparam logic [ReasonW-1:0] REASON_REPEATED = 2'd0;
  localparam logic [ReasonW-1:0] REASON_TIMEOUT  = 2'd1;
  localparam logic [ReasonW-1:0] REASON_REJECTED = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 2'd2;

  // register reset values
  localparam logic [ThrW-1:0]     THRESHOLD_RST = 5'd3;
  localparam logic [LimW-1:0]     WINDOW_LIM_RST = 22'd60999;
  localparam logic [TimeoutW-1:0] TIMEOUT_RST   = 20'd30000;

  typedef struct packed {
    logic               show_alert;
    logic               escalated;
    logic [ReasonW-1:0] escalation_reason;
    logic [TagW-1:0]    message_tag;
  } res_t;

endpackage

FILE: src/aec_in_if.sv
`timescale 1ns / 1ps

interface aec_in_if;
  logic                      valid;
  logic                      ready;
  logic [aec_pkg::OpW-1:0]   operation;
  logic [aec_pkg::TagW-1:0]  alert_tag;
  logic                      confirmed;

  modport source (output valid, operation, alert_tag, confirmed, input ready);
  modport sink   (input valid, operation, alert_tag, confirmed, output ready);
endinterface

FILE: src/aec_out_if.sv
`timescale 1ns / 1ps

interface aec_out_if;
  logic                         valid;
  logic                         ready;
  logic                         show_alert;
  logic                         escalated;
  logic [aec_pkg::ReasonW-1:0]  escalation_reason;
  logic [aec_pkg::TagW-1:0]     message_tag;
  logic                         alert_active;

  modport source (output valid, show_alert, escalated, escalation_reason, message_tag,
                  alert_active, input ready);
  modport sink   (input valid, show_alert, escalated, escalation_reason, message_tag,
                  alert_active, output ready);
endinterface

FILE: src/alert_escalation_controller.sv
`timescale 1ns / 1ps

// Alert escalation controller. Every input beat (millisecond tick, new alert or
// operator response) yields exactly one output beat. Ticks, responses and the
// unused operation code reach the result register in the cycle after acceptance.
// An alert first scans the ring and drops its E expired timestamps (0 to
// MaxThreshold-1) before its result is registered: the timestamps live in a synchronous
// memory of MaxThreshold entries with one read and one write port, and the scan
// pops one entry per cycle, each pop reading the next head entry through the
// registered read port. A new
// beat is accepted whenever the controller is idle, also while the previous
// result still waits on the output; a result only waits for the output register
// to free up. Configuration writes are taken at any time but are meant for an
// idle block; the window register is stored as a limit in milliseconds.
module alert_escalation_controller #(
  parameter int unsigned MaxThreshold = aec_pkg::MAX_THRESHOLD,
  parameter int unsigned TimeWidth    = aec_pkg::TIME_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aec_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aec_pkg::CfgDataW-1:0]  cfg_wdata_i,
  aec_in_if.sink                        in_i,
  aec_out_if.source                     out_o
);

  localparam int unsigned IdxW = (MaxThreshold > 1) ? $clog2(MaxThreshold) : 1;
  localparam int unsigned CntW = $clog2(MaxThreshold + 1);
  localparam int unsigned CmpW = ((CntW > aec_pkg::ThrW) ? CntW : aec_pkg::ThrW) + 1;
  localparam int unsigned SumW = IdxW + 1;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  // configuration registers
  logic [aec_pkg::ThrW-1:0]     thr_q;
  logic [aec_pkg::LimW-1:0]     lim_q;
  logic [aec_pkg::TimeoutW-1:0] resp_q;

  // controller state
  logic [1:0]                   state_q, state_d;
  logic                         active_q, active_d;
  logic [aec_pkg::TagW-1:0]     cur_tag_q, cur_tag_d;
  logic [aec_pkg::TimeoutW-1:0] timeout_q, timeout_d;
  logic [TimeWidth-1:0]         now_q, now_d;
  logic [IdxW-1:0]              head_q, head_d;
  logic [CntW-1:0]              count_q, count_d;

  // staged result and output register
  aec_pkg::res_t                res_q, res_d;
  aec_pkg::res_t                out_res_q, out_res_d;
  logic                         out_active_q, out_active_d;
  logic                         out_valid_q, out_valid_d;

  // timestamp ring
  logic [TimeWidth-1:0]         ring_mem [MaxThreshold];
  logic [TimeWidth-1:0]         rdata_q;
  logic                         mem_we;
  logic [IdxW-1:0]              waddr;
  logic [SumW-1:0]              wsum;

  logic                         in_fire;
  logic [TimeWidth-1:0]         age;
  logic                         expired;
  logic [CmpW-1:0]              thr_cmp;
  logic [CmpW-1:0]              cnt_inc;
  logic                         esc_repeat;
  logic [IdxW-1:0]              head_inc;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid             = out_valid_q;
  assign out_o.show_alert        = out_res_q.show_alert;
  assign out_o.escalated         = out_res_q.escalated;
  assign out_o.escalation_reason = out_res_q.escalation_reason;
  assign out_o.message_tag       = out_res_q.message_tag;
  assign out_o.alert_active      = out_active_q;

  // age of the head entry against the window limit (whole seconds <= window)
  assign age     = now_q - rdata_q;
  assign expired = age > TimeWidth'(lim_q);

  // threshold above ring depth acts as the ring depth
  assign thr_cmp = (CmpW'(thr_q) > CmpW'(MaxThreshold)) ? CmpW'(MaxThreshold)
                                                         : CmpW'(thr_q);
  assign cnt_inc    = CmpW'(count_q) + CmpW'(1);
  assign esc_repeat = cnt_inc >= thr_cmp;

  assign head_inc = (head_q == IdxW'(MaxThreshold - 1)) ? '0 : head_q + IdxW'(1);

  // tail slot: head + count wrapped once around the ring
  assign wsum  = SumW'(head_q) + SumW'(count_q);
  assign waddr = (wsum >= SumW'(MaxThreshold)) ? IdxW'(wsum - SumW'(MaxThreshold))
                                               : IdxW'(wsum);

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    cur_tag_d    = cur_tag_q;
    timeout_d    = timeout_q;
    now_d        = now_q;
    head_d       = head_q;
    count_d      = count_q;
    res_d        = res_q;
    out_res_d    = out_res_q;
    out_active_d = out_active_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d   = '0;
          state_d = S_PUSH;
          case (in_i.operation)
            aec_pkg::OP_TICK: begin
              now_d = now_q + TimeWidth'(1);
              if (active_q) begin
                if (timeout_q <= aec_pkg::TimeoutW'(1)) begin
                  res_d.escalated         = 1'b1;
                  res_d.escalation_reason = aec_pkg::REASON_TIMEOUT;
                  res_d.message_tag       = cur_tag_q;
                  active_d  = 1'b0;
                  cur_tag_d = '0;
                  timeout_d = '0;
                  head_d    = '0;
                  count_d   = '0;
                end else begin
                  timeout_d = timeout_q - aec_pkg::TimeoutW'(1);
                end
              end
            end
            aec_pkg::OP_ALERT: begin
              // head entry is read this cycle, scan starts with its data
              cur_tag_d = in_i.alert_tag;
              state_d   = S_SCAN;
            end
            aec_pkg::OP_RESPONSE: begin
              if (active_q) begin
                if (!in_i.confirmed) begin
                  res_d.escalated         = 1'b1;
                  res_d.escalation_reason = aec_pkg::REASON_REJECTED;
                  res_d.message_tag       = cur_tag_q;
                end
                active_d  = 1'b0;
                cur_tag_d = '0;
                timeout_d = '0;
                head_d    = '0;
                count_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if ((count_q != '0) && expired) begin
          // drop the oldest entry, next head is read for the following cycle
          head_d  = head_inc;
          count_d = count_q - CntW'(1);
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CntW'(1);
          state_d = S_PUSH;
          if (esc_repeat) begin
            res_d.escalated         = 1'b1;
            res_d.escalation_reason = aec_pkg::REASON_REPEATED;
            res_d.message_tag       = cur_tag_q;
            active_d  = 1'b0;
            cur_tag_d = '0;
            timeout_d = '0;
            head_d    = '0;
            count_d   = '0;
          end else if (!active_q) begin
            res_d.show_alert  = 1'b1;
            res_d.message_tag = cur_tag_q;
            active_d  = 1'b1;
            timeout_d = resp_q;
          end
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_res_d    = res_q;
          out_active_d = active_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      cur_tag_q   <= '0;
      timeout_q   <= '0;
      now_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cur_tag_q   <= cur_tag_d;
      timeout_q   <= timeout_d;
      now_q       <= now_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    out_res_q    <= out_res_d;
    out_active_q <= out_active_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= aec_pkg::THRESHOLD_RST;
      lim_q  <= aec_pkg::WINDOW_LIM_RST;
      resp_q <= aec_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        aec_pkg::CFG_THRESHOLD: thr_q <= cfg_wdata_i[aec_pkg::ThrW-1:0];
        aec_pkg::CFG_WINDOW: begin
          lim_q <= aec_pkg::LimW'(cfg_wdata_i[aec_pkg::WindowW-1:0])
                   * aec_pkg::LimW'(aec_pkg::MsPerSec)
                   + aec_pkg::LimW'(aec_pkg::MsPerSec - 1);
        end
        aec_pkg::CFG_TIMEOUT: resp_q <= cfg_wdata_i[aec_pkg::TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  // timestamp memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[waddr] <= now_q;
    end
    rdata_q <= ring_mem[head_d];
  end

endmodule

FILE: src/aec_checker.sv
`timescale 1ns / 1ps

module aec_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        show_alert_i,
  input logic                        escalated_i,
  input logic [aec_pkg::ReasonW-1:0] escalation_reason_i,
  input logic [aec_pkg::TagW-1:0]    message_tag_i,
  input logic                        alert_active_i
);

  // a beat that is not taken stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat withdrawn before it was taken");

  // an escalation always leaves the controller idle, never with a shown alert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && escalated_i |-> !alert_active_i && !show_alert_i)
    else $error("escalation left an alert active or shown");

  // a shown alert is waiting for the operator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && show_alert_i |-> alert_active_i)
    else $error("shown alert is not active");

  // unused result fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !escalated_i |->
      (escalation_reason_i == '0) && (show_alert_i || (message_tag_i == '0)))
    else $error("unused result field is not zero");

endmodule

bind alert_escalation_controller aec_checker u_aec_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .show_alert_i        (out_o.show_alert),
  .escalated_i         (out_o.escalated),
  .escalation_reason_i (out_o.escalation_reason),
  .message_tag_i       (out_o.message_tag),
  .alert_active_i      (out_o.alert_active)
);
